/* rtl/rcd_pkg.sv */
// Package for the chunk stream deparser: field widths, header lengths,
// error codes and the per-stream table entry type. No dependencies.
package rcd_pkg;

  localparam int NUM_STREAMS_DEF = 64;
  localparam int ID_W            = 17;
  localparam int SIZE_W          = 17;
  localparam int LEN_W           = 24;
  localparam int TS_W            = 32;
  localparam int OUT_W           = 128;

  localparam logic [SIZE_W-1:0] CHUNK_SIZE_RST = 17'd128;
  localparam logic [23:0]       TS_ESCAPE      = 24'hFFFFFF;
  localparam logic [5:0]        ID_MASK        = 6'h3f;
  localparam logic [ID_W-1:0]   ID_TWO_BYTE    = 17'd64;

  localparam logic [1:0] ERR_BAD_FORMAT = 2'd0;
  localparam logic [1:0] ERR_STREAM_ID  = 2'd1;
  localparam logic [1:0] ERR_LENGTH     = 2'd2;

  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic [LEN_W-1:0] len;
    logic [7:0]       mtype;
    logic [31:0]      msid;
    logic             ext;
    logic [LEN_W-1:0] rec;
  } entry_t;

  function automatic logic [3:0] mh_len(input logic [1:0] fmt);
    case (fmt)
      2'd0:    mh_len = 4'd11;
      2'd1:    mh_len = 4'd7;
      2'd2:    mh_len = 4'd3;
      default: mh_len = 4'd0;
    endcase
  endfunction

endpackage

/* rtl/rtmp_chunk_deparser_unit.sv */
// Chunk stream deparser: one byte in on s_*, one tagged payload byte or
// error report out on m_*. Per-stream headers live in a synchronous table.
// Depends on rcd_pkg.
//
// Usage:
//   s_tdata carries the received byte stream; a byte is taken when s_tvalid
//   and s_tready are high. m_tdata carries the result, m_tuser marks an error
//   report, m_tlast marks the byte that completes a message.
//   cfg_we/cfg_wdata write the chunk size (reset 128). The user must write
//   it only while the block is idle; the block itself does not enforce this.
//   A payload byte appears on m_* in the cycle after it is taken.
//   Throughput: one byte per cycle while the receiver does not stall, except
//   after each basic header, while the table read for the new chunk stream
//   returns and the start format is checked in DEC (s_tready is low then).
//   The output register frees in the cycle it is taken, so a new byte is
//   accepted while m_tready is high even with m_tvalid set; when the receiver
//   stalls, s_tready drops and the result holds.
//   Reset clears the parse state, the partial-message marks and the halt; the
//   table contents are not cleared and need no clearing pass. After an error
//   report every further byte is accepted and dropped until reset.
module rtmp_chunk_deparser_unit #(
  parameter int NUM_STREAMS = rcd_pkg::NUM_STREAMS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rcd_pkg::SIZE_W-1:0] cfg_wdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // rx_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // error_code, data_byte, chunk_stream_id, msg_type_id, timestamp,
  // message_length, message_stream_id, first_of_message, zero fill
  output logic [rcd_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tuser,   // error_flag
  output logic                      m_tlast    // last_of_message
);

  localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  typedef enum logic [2:0] {BH0, BH1, BH2, DEC, MH, EXT, PAY} phase_t;

  phase_t                      phase, phase_next;
  logic [3:0]                  hbc, hbc_next;
  logic [1:0]                  fmt, fmt_next;
  logic [rcd_pkg::ID_W-1:0]    csid, csid_next;
  logic [31:0]                 fs, fs_next;
  logic [rcd_pkg::SIZE_W-1:0]  left, left_next;
  logic                        halted, halt_next;
  logic [rcd_pkg::SIZE_W-1:0]  chunk_size;
  logic [NUM_STREAMS-1:0]      inmsg;

  rcd_pkg::entry_t             mem [NUM_STREAMS];
  rcd_pkg::entry_t             rd_data, cache, n;
  logic [AW-1:0]               cache_id, rd_addr;
  logic                        cache_valid, hit;
  logic                        rd_req;

  logic                        out_free, step, produce;
  logic                        im_we, im_val;
  logic                        o_err, o_first, o_last;
  logic [1:0]                  o_code;
  logic [7:0]                  o_data;
  logic                        do_after, do_finish;
  logic [rcd_pkg::ID_W-1:0]    new_id;
  logic                        id_ok;
  logic [rcd_pkg::LEN_W-1:0]   diff, rec1;
  logic [rcd_pkg::SIZE_W-1:0]  left_dec;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = out_free && (phase != DEC);
  assign step     = (phase == DEC) ? out_free : (s_tvalid && s_tready);
  assign hit      = cache_valid && (cache_id == csid[AW-1:0]);
  assign id_ok    = csid < rcd_pkg::ID_W'(NUM_STREAMS);

  always_comb begin
    n          = cache;
    if (phase == DEC) begin
      n = hit ? cache : rd_data;
    end
    phase_next = phase;
    hbc_next   = hbc;
    fmt_next   = fmt;
    csid_next  = csid;
    fs_next    = fs;
    left_next  = left;
    halt_next  = halted;
    im_we      = 1'b0;
    im_val     = 1'b0;
    produce    = 1'b0;
    o_err      = 1'b0;
    o_code     = rcd_pkg::ERR_BAD_FORMAT;
    o_data     = '0;
    o_first    = 1'b0;
    o_last     = 1'b0;
    do_after   = 1'b0;
    do_finish  = 1'b0;
    rd_req     = 1'b0;
    new_id     = '0;
    diff       = '0;
    rec1       = '0;
    left_dec   = '0;
    if (step && !halted) begin
      case (phase)
        BH0: begin
          fmt_next = s_tdata[7:6];
          new_id   = rcd_pkg::ID_W'(s_tdata[5:0] & rcd_pkg::ID_MASK);
          if (new_id > rcd_pkg::ID_W'(1)) begin
            rd_req = 1'b1;
          end else begin
            hbc_next   = 4'(new_id) + 4'd1;
            phase_next = BH1;
          end
        end
        BH1: begin
          new_id = rcd_pkg::ID_TWO_BYTE + rcd_pkg::ID_W'(s_tdata);
          if (hbc == 4'd2) begin
            csid_next  = new_id;
            phase_next = BH2;
          end else begin
            rd_req = 1'b1;
          end
        end
        BH2: begin
          new_id = csid + {1'b0, s_tdata, 8'd0};
          rd_req = 1'b1;
        end
        DEC: begin
          if (!id_ok) begin
            produce = 1'b1;
            o_err   = 1'b1;
            o_code  = rcd_pkg::ERR_STREAM_ID;
          end else if (inmsg[csid[AW-1:0]] == (fmt == 2'd0)) begin
            produce = 1'b1;
            o_err   = 1'b1;
            o_code  = rcd_pkg::ERR_BAD_FORMAT;
          end else begin
            if (fmt == 2'd0) begin
              im_we  = 1'b1;
              im_val = 1'b1;
              n.rec  = '0;
            end
            hbc_next = '0;
            fs_next  = '0;
            if (rcd_pkg::mh_len(fmt) != 4'd0) begin
              phase_next = MH;
            end else begin
              do_after = 1'b1;
            end
          end
        end
        MH: begin
          if (hbc < 4'd3) begin
            fs_next = {fs[23:0], s_tdata};
            if (hbc == 4'd2) begin
              n.ts  = (fmt == 2'd0) ? 32'(fs_next[23:0]) : n.ts + 32'(fs_next[23:0]);
              n.ext = (fs_next[23:0] == rcd_pkg::TS_ESCAPE);
              if (n.ext) begin
                n.ts = 32'(rcd_pkg::TS_ESCAPE);
              end
            end
          end else if (hbc < 4'd6) begin
            n.len = (hbc == 4'd3) ? 24'(s_tdata) : {n.len[15:0], s_tdata};
          end else if (hbc == 4'd6) begin
            n.mtype = s_tdata;
          end else if (hbc <= 4'd10) begin
            n.msid = ((hbc == 4'd7) ? 32'd0 : n.msid)
                   | (32'(s_tdata) << {hbc[1:0] - 2'd3, 3'd0});
          end
          hbc_next = hbc + 4'd1;
          if (hbc_next >= rcd_pkg::mh_len(fmt)) begin
            do_after = 1'b1;
          end
        end
        EXT: begin
          fs_next  = {fs[23:0], s_tdata};
          hbc_next = hbc + 4'd1;
          if (hbc_next >= 4'd4) begin
            n.ts      = fs_next;
            do_finish = 1'b1;
          end
        end
        PAY: begin
          rec1    = n.rec + 24'd1;
          o_first = (n.rec == '0);
          o_last  = (rec1 == n.len);
          n.rec   = rec1;
          produce = 1'b1;
          o_data  = s_tdata;
          left_dec = (left != '0) ? left - 17'd1 : left;
          left_next = left_dec;
          if (o_last) begin
            im_we      = 1'b1;
            phase_next = BH0;
          end else if (left_dec == '0) begin
            phase_next = BH0;
          end
        end
        default: phase_next = BH0;
      endcase
      if (rd_req) begin
        csid_next  = new_id;
        phase_next = DEC;
      end
      if (do_after) begin
        if (n.ext) begin
          phase_next = EXT;
          hbc_next   = '0;
          fs_next    = '0;
        end else begin
          do_finish = 1'b1;
        end
      end
      if (do_finish) begin
        if (n.len < n.rec) begin
          produce = 1'b1;
          o_err   = 1'b1;
          o_code  = rcd_pkg::ERR_LENGTH;
        end else begin
          phase_next = BH0;
          hbc_next   = '0;
          if (n.len == n.rec) begin
            im_we = 1'b1;
          end else begin
            diff = n.len - n.rec;
            left_next = (diff > 24'(chunk_size)) ? chunk_size : diff[rcd_pkg::SIZE_W-1:0];
            if (left_next != '0) begin
              phase_next = PAY;
            end
          end
        end
      end
      if (o_err) begin
        halt_next  = 1'b1;
        phase_next = BH0;
        hbc_next   = '0;
        im_we      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= BH0;
      hbc         <= '0;
      fmt         <= '0;
      csid        <= '0;
      fs          <= '0;
      left        <= '0;
      halted      <= 1'b0;
      chunk_size  <= rcd_pkg::CHUNK_SIZE_RST;
      inmsg       <= '0;
      cache_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      phase  <= phase_next;
      hbc    <= hbc_next;
      fmt    <= fmt_next;
      csid   <= csid_next;
      fs     <= fs_next;
      left   <= left_next;
      halted <= halt_next;
      if (cfg_we) begin
        chunk_size <= cfg_wdata;
      end
      if (im_we) begin
        inmsg[csid[AW-1:0]] <= im_val;
      end
      if (step && !halted && phase == DEC && id_ok) begin
        cache_valid <= 1'b1;
      end
      if (produce) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !halted) begin
      cache <= n;
      if (phase == DEC) begin
        cache_id <= csid[AW-1:0];
      end
    end
    if (produce) begin
      m_tuser <= o_err;
      m_tlast <= o_err ? 1'b0 : o_last;
      m_tdata <= o_err ? {101'd0, csid, 8'd0, o_code}
                       : {4'd0, o_first, n.msid, n.len, n.ts, n.mtype, csid, o_data, 2'd0};
    end
  end

  assign rd_addr = new_id[AW-1:0];

  always_ff @(posedge clk) begin
    if (rd_req && !o_err) begin
      if (cache_valid) begin
        mem[cache_id] <= cache;
      end
      if (new_id < rcd_pkg::ID_W'(NUM_STREAMS)) begin
        rd_data <= mem[rd_addr];
      end
    end
  end

  a_dec_stall: assert property (@(posedge clk) disable iff (rst)
    (phase == DEC) |-> !s_tready)
    else $error("byte accepted during table lookup");

  a_halt_err: assert property (@(posedge clk) disable iff (rst)
    $rose(halted) |-> (m_tvalid && m_tuser))
    else $error("halt without error report");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (halted && $past(halted)) |-> !$rose(m_tvalid))
    else $error("result produced while halted");

  a_pay_valid: assert property (@(posedge clk) disable iff (rst)
    (phase == PAY) |-> (cache_valid && id_ok))
    else $error("payload without a loaded stream entry");

endmodule
